// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CWMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CWMA_ASSERT(lbl, clk, rst_n, prop, msg)
`define CWMA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/cwma_pkg.sv
// ----------------------------------------------------------------------------
// cwma_pkg
// Shared constants and types of the cascaded window moment accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package cwma_pkg;

    localparam int MAX_LEVELS  = 8;
    localparam int FRAC_BITS   = 4;
    localparam int LVL_W       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int SAMPLE_W    = 20;
    localparam int VAL_W       = SAMPLE_W + FRAC_BITS;
    localparam int IDX_W       = 3;
    localparam int SUM_W       = 64;
    localparam int CNT_W       = 32;
    localparam int POS_W       = 16;
    localparam int WLEN_W      = 16;
    localparam int MOM_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int MUL_LAST_PH = 4;
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(10);
    localparam logic [MOM_W-1:0]  MOM_RESET  = MOM_W'(3);

    typedef enum logic
    {
        OP_FEED = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_WLEN    = 1'b0,
        CFG_MOMENTS = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SQ,
        S_CUBE,
        S_UPD,
        S_DIV
    } state_t;

    typedef struct packed
    {
        op_t              op;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed
    {
        logic [WLEN_W-1:0] wlen;
        logic [MOM_W-1:0]  moments;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/cwma_front.sv
// ----------------------------------------------------------------------------
// cwma_front
// Input register: takes items, converts samples to Q.4 and forwards commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cwma_front
    import cwma_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                feed_valid,
    output logic                     feed_stall,
    input  wire logic                operation,
    input  wire logic [SAMPLE_W-1:0] sample_value,
    input  wire logic [IDX_W-1:0]    level_index,
    input  wire logic                q_full,
    output logic                     q_push,
    output cmd_t                     q_cmd
);

    logic fe_valid_reg;
    logic fe_valid_next;
    cmd_t fe_cmd_reg;
    cmd_t fe_cmd_next;

    assign feed_stall = fe_valid_reg && q_full;
    assign q_push     = fe_valid_reg && !q_full;
    assign q_cmd      = fe_cmd_reg;

    always_comb
    begin
        fe_valid_next = fe_valid_reg;
        fe_cmd_next   = fe_cmd_reg;
        if (!feed_stall)
        begin
            fe_valid_next     = feed_valid;
            fe_cmd_next.op    = op_t'(operation);
            fe_cmd_next.value = {sample_value, {FRAC_BITS{1'b0}}};
            fe_cmd_next.idx   = level_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else
        begin
            fe_valid_reg <= fe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fe_cmd_reg <= fe_cmd_next;
    end

endmodule

`default_nettype wire

// File: sv/cwma_queue.sv
// ----------------------------------------------------------------------------
// cwma_queue
// Short command FIFO between the front and the level engine.
// ----------------------------------------------------------------------------
`default_nettype none

module cwma_queue
    import cwma_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/cwma_back.sv
// ----------------------------------------------------------------------------
// cwma_back
// Level engine: walks the cascade with a shared 32x32 multiplier and a
// radix-2 divider, keeps per-level sums, and serves reads.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cwma_back
    import cwma_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  cfg_t                cfg,
    input  wire logic           q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                result_valid,
    input  wire logic           result_stall,
    output logic                level_present,
    output logic [SUM_W-1:0]    first_power_sum,
    output logic [SUM_W-1:0]    second_power_sum,
    output logic [SUM_W-1:0]    third_power_sum,
    output logic [CNT_W-1:0]    value_count,
    output logic                saturation_seen
);

    // per-level state
    logic [SUM_W-1:0]      sum1_reg [MAX_LEVELS];
    logic [SUM_W-1:0]      sum2_reg [MAX_LEVELS];
    logic [SUM_W-1:0]      sum3_reg [MAX_LEVELS];
    logic [SUM_W-1:0]      snap_reg [MAX_LEVELS];
    logic [POS_W-1:0]      pos_reg  [MAX_LEVELS];
    logic [CNT_W-1:0]      cnt_reg  [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] active_reg;
    logic                  sticky_reg;
    logic                  sticky_next;

    state_t state_reg;
    state_t state_next;

    logic [LVL_W-1:0]     lvl_reg;
    logic [LVL_W-1:0]     lvl_next;
    logic [SUM_W-1:0]     v_reg;
    logic [SUM_W-1:0]     v_next;
    logic [SUM_W-1:0]     sq_reg;
    logic [SUM_W-1:0]     sq_next;
    logic [SUM_W-1:0]     cube_reg;
    logic [SUM_W-1:0]     cube_next;
    logic                 msq_reg;
    logic                 msq_next;
    logic                 mcube_reg;
    logic                 mcube_next;

    // multiplier
    logic [2:0]           ph_reg;
    logic [2:0]           ph_next;
    logic [1:0]           prod_sh_reg;
    logic [1:0]           prod_sh_next;
    logic [SUM_W-1:0]     prod_reg;
    logic [SUM_W-1:0]     prod_next;
    logic [2*SUM_W-1:0]   acc_reg;
    logic [2*SUM_W-1:0]   acc_next;
    logic [2*SUM_W-1:0]   acc_sum;
    logic [2*SUM_W-1:0]   prod_shifted;
    logic [SUM_W-1:0]     mul_op_a;
    logic [31:0]          mul_a_part;
    logic [31:0]          mul_b_part;
    logic                 mul_last;
    logic                 mul_sat;
    logic [SUM_W-1:0]     mul_res;

    // divider
    logic [SUM_W-1:0]     div_q_reg;
    logic [SUM_W-1:0]     div_q_next;
    logic [WLEN_W-1:0]    div_r_reg;
    logic [WLEN_W-1:0]    div_r_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic [WLEN_W:0]      rem_sh;
    logic                 rem_ge;
    logic                 div_done;

    // output register
    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 res_present_reg;
    logic [SUM_W-1:0]     res_sum1_reg;
    logic [SUM_W-1:0]     res_sum2_reg;
    logic [SUM_W-1:0]     res_sum3_reg;
    logic [CNT_W-1:0]     res_cnt_reg;
    logic                 res_sticky_reg;
    logic                 res_load;
    logic                 out_free;
    logic                 rd_in_range;

    // level update
    logic [LVL_W-1:0]     rd_addr;
    logic [WLEN_W-1:0]    len_eff;
    logic                 mom2;
    logic                 mom3;
    logic                 lvl_last;
    logic [SUM_W:0]       add1;
    logic [SUM_W:0]       add2;
    logic [SUM_W:0]       add3;
    logic [SUM_W-1:0]     upd_sum1;
    logic [SUM_W-1:0]     upd_sum2;
    logic [SUM_W-1:0]     upd_sum3;
    logic [CNT_W-1:0]     upd_cnt;
    logic [POS_W:0]       pos_inc;
    logic                 win_close;
    logic                 upd_sat;
    logic                 upd_we;

    assign len_eff  = (cfg.wlen == '0) ? WLEN_W'(1) : cfg.wlen;
    assign mom2     = (cfg.moments >= MOM_W'(2));
    assign mom3     = (cfg.moments == MOM_W'(3));
    assign lvl_last = (lvl_reg == LVL_W'(MAX_LEVELS - 1));
    assign rd_addr  = (state_reg == S_IDLE) ? LVL_W'(q_cmd.idx) : lvl_reg;

    // ---- multiplier: four 32x32 partial products, registered, then summed
    assign mul_op_a   = (state_reg == S_CUBE) ? sq_reg : v_reg;
    assign mul_a_part = ph_reg[1] ? mul_op_a[63:32] : mul_op_a[31:0];
    assign mul_b_part = ph_reg[0] ? v_reg[63:32] : v_reg[31:0];
    assign prod_next  = SUM_W'(mul_a_part) * SUM_W'(mul_b_part);
    assign prod_sh_next = {1'b0, ph_reg[1]} + {1'b0, ph_reg[0]};

    always_comb
    begin
        case (prod_sh_reg)
            2'd0:    prod_shifted = {64'd0, prod_reg};
            2'd1:    prod_shifted = {32'd0, prod_reg, 32'd0};
            default: prod_shifted = {prod_reg, 64'd0};
        endcase
    end

    assign acc_sum  = (ph_reg == 3'd0) ? acc_reg : acc_reg + prod_shifted;
    assign mul_last = (ph_reg == 3'(MUL_LAST_PH));
    assign mul_sat  = (acc_sum[2*SUM_W-1:SUM_W] != '0);
    assign mul_res  = mul_sat ? '1 : acc_sum[SUM_W-1:0];

    // ---- divider: one quotient bit per cycle
    assign rem_sh   = {div_r_reg, div_q_reg[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, len_eff});
    assign div_done = (div_cnt_reg == '1);

    // ---- level update
    assign add1     = {1'b0, sum1_reg[rd_addr]} + {1'b0, v_reg};
    assign add2     = {1'b0, sum2_reg[rd_addr]} + {1'b0, sq_reg};
    assign add3     = {1'b0, sum3_reg[rd_addr]} + {1'b0, cube_reg};
    assign upd_sum1 = add1[SUM_W] ? '1 : add1[SUM_W-1:0];
    assign upd_sum2 = !mom2 ? sum2_reg[rd_addr] : (add2[SUM_W] ? '1 : add2[SUM_W-1:0]);
    assign upd_sum3 = !mom3 ? sum3_reg[rd_addr] : (add3[SUM_W] ? '1 : add3[SUM_W-1:0]);
    assign upd_cnt  = (cnt_reg[rd_addr] == '1) ? cnt_reg[rd_addr] : cnt_reg[rd_addr] + 1'b1;
    assign pos_inc  = {1'b0, pos_reg[rd_addr]} + 1'b1;
    assign win_close = (pos_inc >= {1'b0, len_eff});
    assign upd_sat  = add1[SUM_W] || (mom2 && (add2[SUM_W] || msq_reg))
                      || (mom3 && (add3[SUM_W] || mcube_reg));
    assign upd_we   = (state_reg == S_UPD);

    // ---- reads
    assign out_free    = !res_valid_reg || !result_stall;
    assign rd_in_range = (32'(q_cmd.idx) < 32'(MAX_LEVELS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && (q_cmd.op == OP_FEED))
                begin
                    state_next = mom2 ? S_SQ : S_UPD;
                end
            end
            S_SQ:
            begin
                if (mul_last)
                begin
                    state_next = mom3 ? S_CUBE : S_UPD;
                end
            end
            S_CUBE:
            begin
                if (mul_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = (win_close && !lvl_last) ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = mom2 ? S_SQ : S_UPD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop        = 1'b0;
        res_load     = 1'b0;
        lvl_next     = lvl_reg;
        v_next       = v_reg;
        sq_next      = sq_reg;
        cube_next    = cube_reg;
        msq_next     = msq_reg;
        mcube_next   = mcube_reg;
        sticky_next  = sticky_reg;
        ph_next      = 3'd0;
        acc_next     = '0;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && ((q_cmd.op == OP_FEED) || out_free))
                begin
                    q_pop = 1'b1;
                end
                if (q_valid && (q_cmd.op == OP_READ) && out_free)
                begin
                    res_load = 1'b1;
                end
                if (q_valid && (q_cmd.op == OP_FEED))
                begin
                    v_next     = SUM_W'(q_cmd.value);
                    lvl_next   = '0;
                    msq_next   = 1'b0;
                    mcube_next = 1'b0;
                end
            end
            S_SQ, S_CUBE:
            begin
                if (mul_last)
                begin
                    if (state_reg == S_SQ)
                    begin
                        sq_next  = mul_res;
                        msq_next = mul_sat;
                    end
                    else
                    begin
                        cube_next  = mul_res;
                        mcube_next = mul_sat;
                    end
                end
                else
                begin
                    ph_next  = ph_reg + 1'b1;
                    acc_next = acc_sum;
                end
            end
            S_UPD:
            begin
                // the top level drops its mean and flags it
                sticky_next = sticky_reg || upd_sat || (win_close && lvl_last);
                div_q_next   = upd_sum1 - snap_reg[rd_addr];
                div_r_next   = '0;
                div_cnt_next = '0;
            end
            S_DIV:
            begin
                div_r_next   = rem_ge ? WLEN_W'(rem_sh - {1'b0, len_eff}) : rem_sh[WLEN_W-1:0];
                div_q_next   = {div_q_reg[SUM_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_done)
                begin
                    v_next     = {div_q_reg[SUM_W-2:0], rem_ge};
                    lvl_next   = lvl_reg + 1'b1;
                    msq_next   = 1'b0;
                    mcube_next = 1'b0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign res_valid_next = res_load || (res_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            sticky_reg    <= 1'b0;
            active_reg    <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                sum1_reg[i] <= '0;
                sum2_reg[i] <= '0;
                sum3_reg[i] <= '0;
                snap_reg[i] <= '0;
                pos_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            sticky_reg    <= sticky_next;
            if (upd_we)
            begin
                active_reg[rd_addr] <= 1'b1;
                sum1_reg[rd_addr]   <= upd_sum1;
                sum2_reg[rd_addr]   <= upd_sum2;
                sum3_reg[rd_addr]   <= upd_sum3;
                cnt_reg[rd_addr]    <= upd_cnt;
                pos_reg[rd_addr]    <= win_close ? '0 : pos_inc[POS_W-1:0];
                if (win_close)
                begin
                    snap_reg[rd_addr] <= upd_sum1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg     <= lvl_next;
        v_reg       <= v_next;
        sq_reg      <= sq_next;
        cube_reg    <= cube_next;
        msq_reg     <= msq_next;
        mcube_reg   <= mcube_next;
        ph_reg      <= ph_next;
        prod_sh_reg <= prod_sh_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_cnt_reg <= div_cnt_next;
        if (res_load)
        begin
            res_present_reg <= rd_in_range && active_reg[rd_addr];
            res_sum1_reg    <= rd_in_range ? sum1_reg[rd_addr] : '0;
            res_sum2_reg    <= rd_in_range ? sum2_reg[rd_addr] : '0;
            res_sum3_reg    <= rd_in_range ? sum3_reg[rd_addr] : '0;
            res_cnt_reg     <= rd_in_range ? cnt_reg[rd_addr] : '0;
            res_sticky_reg  <= sticky_reg;
        end
    end

    assign result_valid     = res_valid_reg;
    assign level_present    = res_present_reg;
    assign first_power_sum  = res_sum1_reg;
    assign second_power_sum = res_sum2_reg;
    assign third_power_sum  = res_sum3_reg;
    assign value_count      = res_cnt_reg;
    assign saturation_seen  = res_sticky_reg;

    `CWMA_ASSERT_ALWAYS(a_div_not_top, clk, (state_reg == S_DIV) |-> !lvl_last, "divide at top level")
    `CWMA_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> (state_reg == S_IDLE), "pop while busy")
    `CWMA_ASSERT(a_sticky_holds, clk, rst_n, sticky_reg |=> sticky_reg, "sticky flag cleared")
    `CWMA_ASSERT(a_read_result, clk, rst_n, (q_pop && (q_cmd.op == OP_READ)) |=> res_valid_reg, "read lost")

endmodule

`default_nettype wire

// File: sv/cascaded_window_moment_accumulator.sv
// ----------------------------------------------------------------------------
// cascaded_window_moment_accumulator
// Multiscale power-sum accumulator with windowed means cascading up levels.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  feed      feed_valid/feed_stall, operation,
//            sample_value, level_index                      in
//  result    result_valid/result_stall, level_present,
//            *_power_sum, value_count, saturation_seen      out
//  config    cfg_write, cfg_index, cfg_data                 in
//
//  A read passes through the input register and a queue entry to the result
//  register when the queue is empty and the engine idle.
//  A feed is dispatched from idle; then at each level visited the engine forms
//  the power products on the shared 32x32 multiplier, updates the level sums
//  and, when a window closes below the top level, divides by the length in the
//  bit-serial divider to pass the mean up, over at most eight levels.
//  A two-entry queue lets the input side take items while the engine works.
//  Reset clears all level state; configuration returns to length 10, 3 sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_window_moment_accumulator
    import cwma_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WLEN_W-1:0]    cfg_data,
    input  wire logic                 feed_valid,
    output logic                      feed_stall,
    input  wire logic                 operation,
    input  wire logic [SAMPLE_W-1:0]  sample_value,
    input  wire logic [IDX_W-1:0]     level_index,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic                      level_present,
    output logic [SUM_W-1:0]          first_power_sum,
    output logic [SUM_W-1:0]          second_power_sum,
    output logic [SUM_W-1:0]          third_power_sum,
    output logic [CNT_W-1:0]          value_count,
    output logic                      saturation_seen
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WLEN:    cfg_next.wlen    = cfg_data;
                CFG_MOMENTS: cfg_next.moments = cfg_data[MOM_W-1:0];
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wlen    <= WLEN_RESET;
            cfg_reg.moments <= MOM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cwma_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .feed_valid   (feed_valid),
        .feed_stall   (feed_stall),
        .operation    (operation),
        .sample_value (sample_value),
        .level_index  (level_index),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    cwma_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    cwma_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_cmd            (head_cmd),
        .q_pop            (q_pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .level_present    (level_present),
        .first_power_sum  (first_power_sum),
        .second_power_sum (second_power_sum),
        .third_power_sum  (third_power_sum),
        .value_count      (value_count),
        .saturation_seen  (saturation_seen)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cascaded window moment accumulator: a scoreboard
// predicts the level sums, counts and the sticky flag for every read, while
// the bench steps through window lengths and moment counts with random
// bursts, gaps and result back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import cwma_pkg::*;

    typedef struct {
        logic             present;
        logic [SUM_W-1:0] sum1;
        logic [SUM_W-1:0] sum2;
        logic [SUM_W-1:0] sum3;
        logic [CNT_W-1:0] count;
        logic             sat;
    } level_stats_t;

    class moment_scoreboard;
        logic [SUM_W-1:0] sum1 [MAX_LEVELS];
        logic [SUM_W-1:0] sum2 [MAX_LEVELS];
        logic [SUM_W-1:0] sum3 [MAX_LEVELS];
        logic [SUM_W-1:0] snap [MAX_LEVELS];
        int unsigned      pos  [MAX_LEVELS];
        logic [CNT_W-1:0] count [MAX_LEVELS];
        logic             active [MAX_LEVELS];
        logic             sticky;
        logic [WLEN_W-1:0] wlen;
        logic [MOM_W-1:0]  moments;
        level_stats_t      stats_q [$];
        int                errors;
        int                feeds;
        int                reads;

        function new();
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                sum1[i] = '0; sum2[i] = '0; sum3[i] = '0; snap[i] = '0;
                pos[i] = 0; count[i] = '0; active[i] = 1'b0;
            end
            sticky  = 1'b0;
            wlen    = WLEN_RESET;
            moments = MOM_RESET;
            errors  = 0;
            feeds   = 0;
            reads   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [WLEN_W-1:0] data);
            if (idx == CFG_WLEN)
                wlen = data;
            else
                moments = data[MOM_W-1:0];
        endfunction

        function logic [SUM_W-1:0] add_clip(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [SUM_W:0] t;
            t = {1'b0, a} + {1'b0, b};
            if (t[SUM_W])
            begin
                sticky = 1'b1;
                return '1;
            end
            return t[SUM_W-1:0];
        endfunction

        function logic [SUM_W-1:0] mul_clip(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [2*SUM_W-1:0] p;
            p = {{SUM_W{1'b0}}, a} * {{SUM_W{1'b0}}, b};
            if (p[2*SUM_W-1:SUM_W] != '0)
            begin
                sticky = 1'b1;
                return '1;
            end
            return p[SUM_W-1:0];
        endfunction

        function void cascade(logic [SUM_W-1:0] v);
            logic [SUM_W-1:0] len;
            logic [SUM_W-1:0] sq;
            logic [SUM_W-1:0] mean;
            int               moms;
            len  = (wlen == '0) ? SUM_W'(1) : SUM_W'(wlen);
            moms = (moments == '0) ? 1 : int'(moments);
            for (int lvl = 0; lvl < MAX_LEVELS; lvl++)
            begin
                active[lvl] = 1'b1;
                sum1[lvl] = add_clip(sum1[lvl], v);
                if (moms >= 2)
                begin
                    sq = mul_clip(v, v);
                    sum2[lvl] = add_clip(sum2[lvl], sq);
                    if (moms >= 3)
                        sum3[lvl] = add_clip(sum3[lvl], mul_clip(sq, v));
                end
                if (count[lvl] != '1)
                    count[lvl]++;
                pos[lvl]++;
                if (pos[lvl] < len)
                    return;
                pos[lvl]  = 0;
                mean      = (sum1[lvl] - snap[lvl]) / len;
                snap[lvl] = sum1[lvl];
                // mean leaving the top level is lost
                if (lvl + 1 >= MAX_LEVELS)
                begin
                    sticky = 1'b1;
                    return;
                end
                v = mean;
            end
        endfunction

        function void note_input(op_t op, logic [SAMPLE_W-1:0] s, logic [IDX_W-1:0] idx);
            level_stats_t e;
            if (op == OP_FEED)
            begin
                feeds++;
                cascade(SUM_W'(s) << FRAC_BITS);
                return;
            end
            reads++;
            if (idx < MAX_LEVELS)
            begin
                e.present = active[idx];
                e.sum1 = sum1[idx]; e.sum2 = sum2[idx]; e.sum3 = sum3[idx];
                e.count = count[idx];
            end
            else
            begin
                e.present = 1'b0; e.sum1 = '0; e.sum2 = '0; e.sum3 = '0; e.count = '0;
            end
            e.sat = sticky;
            stats_q.push_back(e);
        endfunction

        function void check_result(level_stats_t got);
            level_stats_t e;
            if (stats_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer", $time);
                errors++;
                return;
            end
            e = stats_q.pop_front();
            if (got.present !== e.present)
            begin
                $display("%0t: level_present exp %0d got %0d", $time, e.present, got.present);
                errors++;
            end
            if (got.sum1 !== e.sum1)
            begin
                $display("%0t: first_power_sum exp %h got %h", $time, e.sum1, got.sum1);
                errors++;
            end
            if (got.sum2 !== e.sum2)
            begin
                $display("%0t: second_power_sum exp %h got %h", $time, e.sum2, got.sum2);
                errors++;
            end
            if (got.sum3 !== e.sum3)
            begin
                $display("%0t: third_power_sum exp %h got %h", $time, e.sum3, got.sum3);
                errors++;
            end
            if (got.count !== e.count)
            begin
                $display("%0t: value_count exp %0d got %0d", $time, e.count, got.count);
                errors++;
            end
            if (got.sat !== e.sat)
            begin
                $display("%0t: saturation_seen exp %0d got %0d", $time, e.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WLEN_W-1:0]    cfg_data = '0;
    logic                 feed_valid = 1'b0;
    logic                 feed_stall;
    logic                 operation = 1'b0;
    logic [SAMPLE_W-1:0]  sample_value = '0;
    logic [IDX_W-1:0]     level_index = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 level_present;
    logic [SUM_W-1:0]     first_power_sum;
    logic [SUM_W-1:0]     second_power_sum;
    logic [SUM_W-1:0]     third_power_sum;
    logic [CNT_W-1:0]     value_count;
    logic                 saturation_seen;

    moment_scoreboard sb = new();
    int  burst_left = 0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    int  rx_cycle = 0;
    int  phases = 0;

    always #5 clk = ~clk;

    cascaded_window_moment_accumulator u_top (.*);

    // receiver: own stall pattern plus one long hold-off on request
    always @(negedge clk)
    begin
        logic st;
        rx_cycle++;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            st = 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 3000;
            st = 1'b1;
        end
        else
        begin
            case ((rx_cycle / 300) % 3)
                0: st = 1'b0;
                1: st = ($urandom_range(0, 9) < 3);
                default: st = ($urandom_range(0, 9) < 7);
            endcase
        end
        result_stall <= st;
    end

    always @(posedge clk)
    begin
        level_stats_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.present = level_present;
            got.sum1 = first_power_sum; got.sum2 = second_power_sum;
            got.sum3 = third_power_sum; got.count = value_count;
            got.sat = saturation_seen;
            sb.check_result(got);
        end
    end

    task automatic send_item(op_t op, logic [SAMPLE_W-1:0] s, logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                @(negedge clk);
                feed_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        feed_valid   <= 1'b1;
        operation    <= op;
        sample_value <= s;
        level_index  <= idx;
        do @(posedge clk); while (feed_stall);
        sb.note_input(op, s, idx);
    endtask

    // wait for all reads to come back, then let queued feeds finish
    task automatic drain();
        @(negedge clk);
        feed_valid <= 1'b0;
        while (sb.stats_q.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [WLEN_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic random_item();
        logic [SAMPLE_W-1:0] s;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            s = SAMPLE_W'($urandom_range(0, 255));
        else if (r < 75)
            s = SAMPLE_W'($urandom);
        else if (r < 88)
            s = '1;
        else
            s = '0;
        if ($urandom_range(0, 4) == 0)
            send_item(OP_READ, SAMPLE_W'($urandom), IDX_W'($urandom));
        else
            send_item(OP_FEED, s, IDX_W'($urandom));
    endtask

    initial
    begin
        int wl [6] = '{3, 1, 65535, 2, 10, 1};
        int mo [6] = '{2, 3, 1, 3, 3, 1};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty read, zero and full-scale samples, every level
        send_item(OP_READ, '0, '0);
        send_item(OP_FEED, '0, '1);
        send_item(OP_FEED, '1, '0);
        send_item(OP_FEED, 20'h2AAAA, '0);
        send_item(OP_FEED, 20'h55555, '0);
        for (int i = 0; i < 7; i++)
            send_item(OP_FEED, 20'd1000, '0);
        for (int i = 0; i < MAX_LEVELS; i++)
            send_item(OP_READ, '1, IDX_W'(i));
        drain();

        // a length of one walks every level, so the top level drops means
        write_reg(CFG_WLEN, WLEN_W'(1));
        write_reg(CFG_MOMENTS, WLEN_W'(1));
        send_item(OP_FEED, 20'd7, '0);
        send_item(OP_READ, '0, IDX_W'(MAX_LEVELS - 1));
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_WLEN, WLEN_W'(wl[p]));
            write_reg(CFG_MOMENTS, WLEN_W'(mo[p]));
            phases++;
            if (p == 3)
                hold_req = 1'b1;
            for (int n = 0; n < ((wl[p] == 1) ? 40 : 80); n++)
                random_item();
            send_item(OP_READ, '0, '0);
            drain();
        end
        // shrinking the window after a partial one closes it on the next feed
        write_reg(CFG_WLEN, WLEN_W'(10));
        for (int n = 0; n < 5; n++)
            send_item(OP_FEED, SAMPLE_W'($urandom_range(0, 100)), '0);
        drain();
        write_reg(CFG_WLEN, WLEN_W'(3));
        for (int n = 0; n < 30; n++)
            random_item();
        drain();

        $display("Covered %0d feeds and %0d reads over %0d configuration phases,",
                 sb.feeds, sb.reads, phases + 3);
        $display("including length extremes 1 and 65535 and one to three sums.");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/cwma_pkg.sv
sv/cwma_front.sv
sv/cwma_queue.sv
sv/cwma_back.sv
sv/cascaded_window_moment_accumulator.sv
tb/tb.sv
